[src/phrm_pkg.sv]
package phrm_pkg;
   localparam int AVG_DEPTH_DEF   = 8;
   localparam int SAMPLE_BITS_DEF = 18;
   localparam int DATA_W  = 18;
   localparam int TIME_W  = 32;
   localparam int BPM_W   = 16;
   localparam int ACC_W   = 52;
   localparam logic [15:0] W_DC_OLD = 16'd62259;
   localparam logic [15:0] W_DC_NEW = 16'd3277;
   localparam logic [15:0] W_LP_OLD = 16'd52429;
   localparam logic [15:0] W_LP_NEW = 16'd13107;
   localparam logic [15:0] BPM_NUM  = 16'd60000;
   localparam logic [1:0] CLS_NORMAL = 2'd0;
   localparam logic [1:0] CLS_LOW    = 2'd1;
   localparam logic [1:0] CLS_HIGH   = 2'd2;
   localparam logic [1:0] ST_NOBEAT  = 2'd3;
   localparam logic [2:0] REG_THRESH  = 3'd0;
   localparam logic [2:0] REG_MIN_INT = 3'd1;
   localparam logic [2:0] REG_TIMEOUT = 3'd2;
   localparam logic [2:0] REG_LOW     = 3'd3;
   localparam logic [2:0] REG_HIGH    = 3'd4;

   typedef struct packed {
      logic [DATA_W-1:0] infrared_sample;
      logic [DATA_W-1:0] red_sample;
      logic [TIME_W-1:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [BPM_W-1:0]  bpm_avg;
      logic [DATA_W-1:0] red_raw;
      logic [DATA_W-1:0] ir_echo;
      logic [1:0]        rate_status;
      logic              emergency;
      logic              valid_res;
   } rsp_type;

   // controls for the bit-serial multiply-accumulate unit
   typedef struct packed {
      logic        start;
      logic [15:0] coef;
   } mac_ctl_type;
endpackage

[src/phrm_if.sv]
interface phrm_req_if;
   import phrm_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface phrm_rsp_if;
   import phrm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[src/ppg_heart_rate_monitor.sv]
// PPG heart-rate monitor.
// req channel: one item per sample (infrared, red, millisecond stamp).
// rsp channel: zero or one item per sample; a beat item with the averaged
//   bpm and its class, or a no-beat item after the silence timeout.
// csr port: write enable, index, data; writes are taken any cycle, but
//   registers should only change while the block is idle.
// Each sample runs through a 16-bit shift-add multiplier four times
// (DC old/new, low-pass old/new), then through a detect state.
// A beat adds a 32-step restoring divide of 60000 by the interval, a
// serial sum of the n filled history entries and a 32-step divide by n.
// One sample is in work at a time; req.ready is high only in the idle
// state, so the next sample is taken once the last one is through.
// Reset (synchronous) reloads the register defaults and clears the filter,
// the beat history count and the class history.
// A finished item waits in the rsp register; the next sample is accepted
// while it waits, and its own result waits until the register drains.
module ppg_heart_rate_monitor #(
   parameter int AVG_DEPTH   = phrm_pkg::AVG_DEPTH_DEF,
   parameter int SAMPLE_BITS = phrm_pkg::SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   phrm_req_if.sink    req,
   phrm_rsp_if.source  rsp,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [17:0] csr_write_data
);
   import phrm_pkg::*;
   localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
   localparam int SUM_W  = BPM_W + CNT_W;
   // sample bits that reach the filter; the port carries DATA_W bits
   localparam int IR_BITS = (SAMPLE_BITS < DATA_W) ? SAMPLE_BITS : DATA_W;

   localparam logic [3:0] S_IDLE = 4'd0, S_DC1 = 4'd1, S_DC2 = 4'd2,
      S_LP1 = 4'd3, S_LP2 = 4'd4, S_DET = 4'd5, S_DIV1 = 4'd6, S_SUM = 4'd7,
      S_DIV2 = 4'd8, S_CLS = 4'd9, S_OUT = 4'd10, S_TMO = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [17:0] thr_ff;
   logic [15:0] min_ff, tmo_ff, lo_ff, hi_ff;

   logic [DATA_W-1:0] ir_ff, red_ff;
   logic [TIME_W-1:0] now_ff;
   logic [ACC_W-1:0]  dc_ff, smooth_ff, part_ff;
   logic              armed_off_ff, first_ff;
   logic [TIME_W-1:0] stamp_ff;
   logic [BPM_W-1:0]  hist_mem [AVG_DEPTH];
   logic [SLOT_W-1:0] slot_ff;
   logic [CNT_W-1:0]  filled_ff;
   logic [1:0]        cls0_ff, cls1_ff;
   logic              busy_ff, phase_ff;

   logic [ACC_W-1:0]  xq;
   logic [TIME_W-1:0] delta;
   logic              mac_done;
   logic [ACC_W-1:0]  mac_prod;
   mac_ctl_type       mac_ctl;
   logic [ACC_W-17:0] mac_mag;
   logic [ACC_W-1:0]  ac_val;
   logic              ac_neg, sm_neg;

   // divider: quotient register, remainder, divisor, count
   logic [TIME_W-1:0] dquo_ff, drem_ff, ddiv_ff;
   logic [4:0]        dcnt_ff;
   logic [TIME_W:0]   dtrial;
   logic [SUM_W-1:0]  sum_ff;
   logic [CNT_W-1:0]  sidx_ff;
   logic [BPM_W-1:0]  avg_ff;
   logic [BPM_W-1:0]  hist_rd_ff;
   logic [1:0]        cls;
   rsp_type           out_ff;
   logic              out_valid_ff;
   logic              tmo_hit, out_load;

   assign xq = {{(ACC_W-16-IR_BITS){1'b0}}, ir_ff[IR_BITS-1:0], 16'd0};
   assign delta = now_ff - stamp_ff;
   assign ac_val = xq - dc_ff;
   assign ac_neg = ac_val[ACC_W-1];
   assign sm_neg = smooth_ff[ACC_W-1];
   assign dtrial = {drem_ff, dquo_ff[TIME_W-1]} - {1'b0, ddiv_ff};
   assign tmo_hit = delta >= {16'd0, (tmo_ff == 16'd0) ? 16'd1 : tmo_ff};
   assign out_load = (state_ff == S_OUT || (state_ff == S_TMO && tmo_hit)) &&
                     (!out_valid_ff || rsp.ready);

   always_comb begin
      mac_ctl.start = 1'b0;
      mac_ctl.coef = W_DC_OLD;
      mac_mag = dc_ff[ACC_W-17:0];
      if (state_ff == S_IDLE && req.valid && req.ready) mac_ctl.start = 1'b0;
      unique case (state_ff)
         S_DC1: begin mac_ctl.coef = W_DC_OLD; mac_mag = dc_ff[ACC_W-17:0]; end
         S_DC2: begin mac_ctl.coef = W_DC_NEW; mac_mag = xq[ACC_W-17:0]; end
         S_LP1: begin
            mac_ctl.coef = W_LP_OLD;
            mac_mag = sm_neg ? (~smooth_ff[ACC_W-17:0] + 1'b1) : smooth_ff[ACC_W-17:0];
         end
         S_LP2: begin
            mac_ctl.coef = W_LP_NEW;
            mac_mag = ac_neg ? (~ac_val[ACC_W-17:0] + 1'b1) : ac_val[ACC_W-17:0];
         end
         default: ;
      endcase
      mac_ctl.start = !phase_ff && (state_ff == S_DC1 || state_ff == S_DC2 ||
                                    state_ff == S_LP1 || state_ff == S_LP2);
   end

   phrm_mac u_mac (
      .clock(clock), .reset(reset), .ctl(mac_ctl), .mag(mac_mag),
      .product(mac_prod), .done(mac_done)
   );

   logic [ACC_W-1:0] rnd;
   assign rnd = (mac_prod + 52'd32768) >> 16;

   always_comb begin
      if (avg_ff < lo_ff) cls = CLS_LOW;
      else if (avg_ff > hi_ff) cls = CLS_HIGH;
      else cls = CLS_NORMAL;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 18'd20; min_ff <= 16'd300; tmo_ff <= 16'd1000;
         lo_ff <= 16'd40; hi_ff <= 16'd120;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_THRESH:  thr_ff <= csr_write_data;
            REG_MIN_INT: min_ff <= csr_write_data[15:0];
            REG_TIMEOUT: tmo_ff <= csr_write_data[15:0];
            REG_LOW:     lo_ff <= csr_write_data[15:0];
            REG_HIGH:    hi_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; phase_ff <= 1'b0; dc_ff <= '0; smooth_ff <= '0;
         armed_off_ff <= 1'b0; first_ff <= 1'b1; stamp_ff <= '0;
         slot_ff <= '0; filled_ff <= '0; cls0_ff <= CLS_NORMAL;
         cls1_ff <= CLS_NORMAL; out_valid_ff <= 1'b0; busy_ff <= 1'b0;
      end else begin
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) out_valid_ff <= 1'b0;
         hist_rd_ff <= hist_mem[sidx_ff[SLOT_W-1:0]];
         unique case (state_in)
            S_IDLE: if (req.valid) begin
               ir_ff <= req.data.infrared_sample;
               red_ff <= req.data.red_sample;
               now_ff <= req.data.time_ms;
               busy_ff <= 1'b1;
               state_ff <= S_DC1;
               phase_ff <= 1'b0;
               if (first_ff) begin
                  dc_ff <= {{(ACC_W-16-IR_BITS){1'b0}},
                            req.data.infrared_sample[IR_BITS-1:0], 16'd0};
                  stamp_ff <= req.data.time_ms;
                  first_ff <= 1'b0;
               end
            end
            S_DC1: if (!phase_ff) phase_ff <= 1'b1;
               else if (mac_done) begin
                  part_ff <= mac_prod; phase_ff <= 1'b0; state_ff <= S_DC2;
               end
            S_DC2: if (!phase_ff) phase_ff <= 1'b1;
               else if (mac_done) begin
                  dc_ff <= (part_ff + mac_prod + 52'd32768) >> 16;
                  phase_ff <= 1'b0; state_ff <= S_LP1;
               end
            S_LP1: if (!phase_ff) phase_ff <= 1'b1;
               else if (mac_done) begin
                  part_ff <= sm_neg ? (~rnd + 1'b1) : rnd;
                  phase_ff <= 1'b0; state_ff <= S_LP2;
               end
            S_LP2: if (!phase_ff) phase_ff <= 1'b1;
               else if (mac_done) begin
                  smooth_ff <= part_ff + (ac_neg ? (~rnd + 1'b1) : rnd);
                  phase_ff <= 1'b0; state_ff <= S_DET;
               end
            S_DET: begin
               if (!sm_neg && smooth_ff > {18'd0, thr_ff, 16'd0} && !armed_off_ff) begin
                  if (delta > {16'd0, min_ff} && delta != '0) begin
                     armed_off_ff <= 1'b1;
                     ddiv_ff <= delta;
                     dquo_ff <= {16'd0, BPM_NUM};
                     drem_ff <= '0;
                     dcnt_ff <= 5'd31;
                     state_ff <= S_DIV1;
                  end else state_ff <= S_TMO;
               end else begin
                  if (sm_neg) armed_off_ff <= 1'b0;
                  state_ff <= S_TMO;
               end
            end
            S_DIV1: begin
               if (!dtrial[TIME_W]) begin
                  drem_ff <= dtrial[TIME_W-1:0];
                  dquo_ff <= {dquo_ff[TIME_W-2:0], 1'b1};
               end else begin
                  drem_ff <= {drem_ff[TIME_W-2:0], dquo_ff[TIME_W-1]};
                  dquo_ff <= {dquo_ff[TIME_W-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff - 5'd1;
               if (dcnt_ff == 5'd0) state_ff <= S_SUM;
               sidx_ff <= '0;
               sum_ff <= '0;
            end
            S_SUM: begin
               if (busy_ff) begin
                  hist_mem[slot_ff] <= dquo_ff[BPM_W-1:0];
                  slot_ff <= (slot_ff == SLOT_W'(AVG_DEPTH-1)) ? '0 : slot_ff + 1'b1;
                  if (filled_ff != CNT_W'(AVG_DEPTH)) filled_ff <= filled_ff + 1'b1;
                  busy_ff <= 1'b0;
               end else if (!phase_ff) begin
                  // entry sidx_ff is being read into hist_rd_ff
                  phase_ff <= 1'b1;
               end else if (sidx_ff == filled_ff) begin
                  ddiv_ff <= {{(TIME_W-CNT_W){1'b0}}, filled_ff};
                  dquo_ff <= {{(TIME_W-SUM_W){1'b0}}, sum_ff};
                  drem_ff <= '0;
                  dcnt_ff <= 5'd31;
                  phase_ff <= 1'b0;
                  state_ff <= S_DIV2;
               end else begin
                  sum_ff <= sum_ff + {{CNT_W{1'b0}}, hist_rd_ff};
                  sidx_ff <= sidx_ff + 1'b1;
                  phase_ff <= 1'b0;
               end
            end
            S_DIV2: begin
               if (!dtrial[TIME_W]) begin
                  drem_ff <= dtrial[TIME_W-1:0];
                  dquo_ff <= {dquo_ff[TIME_W-2:0], 1'b1};
               end else begin
                  drem_ff <= {drem_ff[TIME_W-2:0], dquo_ff[TIME_W-1]};
                  dquo_ff <= {dquo_ff[TIME_W-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff - 5'd1;
               if (dcnt_ff == 5'd0) state_ff <= S_CLS;
            end
            S_CLS: begin
               avg_ff <= dquo_ff[BPM_W-1:0];
               state_ff <= S_OUT;
            end
            S_OUT: if (out_load) begin
               out_ff.bpm_avg <= avg_ff;
               out_ff.red_raw <= red_ff;
               out_ff.ir_echo <= ir_ff;
               out_ff.rate_status <= cls;
               out_ff.emergency <= (cls1_ff == cls) && (cls == CLS_LOW || cls == CLS_HIGH);
               out_ff.valid_res <= 1'b1;
               cls0_ff <= cls1_ff; cls1_ff <= cls;
               stamp_ff <= now_ff;
               busy_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            S_TMO: begin
               if (tmo_hit) begin
                  if (out_load) begin
                     out_ff.bpm_avg <= '0;
                     out_ff.red_raw <= red_ff;
                     out_ff.ir_echo <= ir_ff;
                     out_ff.rate_status <= ST_NOBEAT;
                     out_ff.emergency <= (cls1_ff == CLS_LOW);
                     out_ff.valid_res <= 1'b0;
                     cls0_ff <= cls1_ff; cls1_ff <= CLS_LOW;
                     stamp_ff <= now_ff;
                     busy_ff <= 1'b0;
                     state_ff <= S_IDLE;
                  end
               end else begin
                  busy_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[src/phrm_mac.sv]
// Shift-add multiplier: product = mag * coef, one coefficient bit per cycle;
// done rises once all 16 coefficient bits have been added in.
module phrm_mac (
   input  logic                           clock,
   input  logic                           reset,
   input  phrm_pkg::mac_ctl_type          ctl,
   input  logic [phrm_pkg::ACC_W-17:0]    mag,
   output logic [phrm_pkg::ACC_W-1:0]     product,
   output logic                           done
);
   import phrm_pkg::*;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [15:0]      coef_ff, coef_in;
   logic [ACC_W-1:0] mcand_ff, mcand_in;
   logic [4:0]       cnt_ff, cnt_in;

   always_comb begin
      acc_in = acc_ff;
      coef_in = coef_ff;
      mcand_in = mcand_ff;
      cnt_in = cnt_ff;
      if (ctl.start) begin
         acc_in = '0;
         coef_in = ctl.coef;
         mcand_in = {16'd0, mag};
         cnt_in = 5'd16;
      end else if (cnt_ff != 5'd0) begin
         if (coef_ff[0]) acc_in = acc_ff + mcand_ff;
         coef_in = coef_ff >> 1;
         mcand_in = mcand_ff << 1;
         cnt_in = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      coef_ff <= coef_in;
      mcand_ff <= mcand_in;
   end

   assign product = acc_ff;
   assign done = (cnt_ff == 5'd0);
endmodule
